// File: design/kee_pkg.sv
package kee_pkg;

    // default expression length limit, in keys
    localparam int MAX_LEN_DEFAULT = 40;

    // entries in the queue between classifier and executor
    localparam int QUEUE_DEPTH = 4;

    // key codes
    localparam logic [7:0] KEY_EQUALS = 8'h3D;
    localparam logic [7:0] KEY_PLUS   = 8'h2B;
    localparam logic [7:0] KEY_MINUS  = 8'h2D;
    localparam logic [7:0] KEY_TIMES  = 8'h2A;
    localparam logic [7:0] KEY_DIVIDE = 8'h2F;
    localparam logic [7:0] KEY_ZERO   = 8'h30;
    localparam logic [7:0] KEY_NINE   = 8'h39;

    typedef enum logic [2:0] {
        OP_PLUS,
        OP_MINUS,
        OP_TIMES,
        OP_DIVIDE,
        OP_OTHER
    } op_t;

    typedef enum logic [1:0] {
        KIND_DIGIT,
        KIND_OPERATOR,
        KIND_EVALUATE
    } kind_t;

    // one classified key as it sits in the queue
    typedef struct packed {
        kind_t      kind;
        logic [3:0] digit;
        op_t        op;
    } entry_t;

    // divider request and response
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

    function automatic op_t decode_op(input logic [7:0] key);
        op_t op;
        unique case (key)
            KEY_PLUS:   op = OP_PLUS;
            KEY_MINUS:  op = OP_MINUS;
            KEY_TIMES:  op = OP_TIMES;
            KEY_DIVIDE: op = OP_DIVIDE;
            default:    op = OP_OTHER;
        endcase
        return op;
    endfunction

endpackage

// File: design/kee_front.sv
module kee_front #(
    parameter int MAX_LEN = kee_pkg::MAX_LEN_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,     // [7:0] key_code
    input  logic            queue_full,
    output logic            push,
    output kee_pkg::entry_t push_entry
);
    import kee_pkg::*;

    localparam int CountWidth = $clog2(MAX_LEN);
    localparam logic [CountWidth-1:0] CountLimit = CountWidth'(MAX_LEN - 1);

    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] count_next;
    logic                  accept;
    logic                  is_eval;
    logic                  is_digit;
    logic                  at_limit;
    logic [7:0]            digit_wide;

    // key classification
    assign s_tready   = !queue_full;
    assign accept     = s_tvalid && s_tready;
    assign is_eval    = (s_tdata == KEY_EQUALS);
    assign is_digit   = (s_tdata >= KEY_ZERO) && (s_tdata <= KEY_NINE);
    assign at_limit   = (count_reg == CountLimit);
    assign digit_wide = s_tdata - KEY_ZERO;

    // keys past the limit are dropped, '=' always goes through
    assign push = accept && (is_eval || !at_limit);

    always_comb begin
        push_entry.digit = digit_wide[3:0];
        push_entry.op    = decode_op(s_tdata);
        if (is_eval) begin
            push_entry.kind = KIND_EVALUATE;
        end else if (is_digit) begin
            push_entry.kind = KIND_DIGIT;
        end else begin
            push_entry.kind = KIND_OPERATOR;
        end
    end

    // key counter per expression
    always_comb begin
        count_next = count_reg;
        if (accept) begin
            if (is_eval) begin
                count_next = '0;
            end else if (!at_limit) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CountLimit)
        else $error("key count beyond limit");

endmodule

// File: design/kee_fifo.sv
module kee_fifo #(
    parameter int DEPTH = kee_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  kee_pkg::entry_t push_entry,
    input  logic            pop,
    output kee_pkg::entry_t pop_entry,
    output logic            full,
    output logic            empty
);
    import kee_pkg::*;

    localparam int AddrWidth  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CountWidth = $clog2(DEPTH + 1);
    localparam logic [AddrWidth-1:0]  LastAddr  = AddrWidth'(DEPTH - 1);
    localparam logic [CountWidth-1:0] FullCount = CountWidth'(DEPTH);

    entry_t                slot_reg [DEPTH];
    logic [AddrWidth-1:0]  wr_ptr_reg;
    logic [AddrWidth-1:0]  rd_ptr_reg;
    logic [CountWidth-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full      = (count_reg == FullCount);
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LastAddr) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LastAddr) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

    a_level_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FullCount)
        else $error("queue level out of range");

endmodule

// File: design/kee_div.sv
module kee_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  kee_pkg::div_req_t req,
    output kee_pkg::div_rsp_t rsp
);
    import kee_pkg::*;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_FIX
    } dv_state_t;

    dv_state_t   state_reg,   state_next;
    logic [31:0] rem_reg,     rem_next;
    logic [31:0] quo_reg,     quo_next;
    logic [31:0] dsr_reg,     dsr_next;
    logic        neg_reg,     neg_next;
    logic [4:0]  step_reg,    step_next;
    logic        done_reg,    done_next;
    logic [31:0] result_reg,  result_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    // one restoring step per cycle on magnitudes
    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dsr_next    = dsr_reg;
        neg_next    = neg_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            DV_IDLE: begin
                if (req.start) begin
                    quo_next   = req.dividend[31] ? -req.dividend : req.dividend;
                    dsr_next   = req.divisor[31] ? -req.divisor : req.divisor;
                    neg_next   = req.dividend[31] ^ req.divisor[31];
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = DV_RUN;
                end
            end
            DV_RUN: begin
                if (!diff[32]) begin
                    rem_next = diff[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end else begin
                    rem_next = shifted[31:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 5'd31) begin
                    state_next = DV_FIX;
                end
            end
            DV_FIX: begin
                // sign of the quotient, truncated toward zero
                result_next = neg_reg ? -quo_reg : quo_reg;
                done_next   = 1'b1;
                state_next  = DV_IDLE;
            end
            default: state_next = DV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dsr_reg    <= dsr_next;
        neg_reg    <= neg_next;
        step_reg   <= step_next;
        result_reg <= result_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = result_reg;

    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> state_reg == DV_IDLE)
        else $error("divider started while busy");

    a_done_after_fix: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(state_reg == DV_FIX))
        else $error("divider done without sign fix");

endmodule

// File: design/kee_back.sv
module kee_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              empty,
    input  kee_pkg::entry_t   entry,
    output logic              pop,
    output kee_pkg::div_req_t div_req,
    input  kee_pkg::div_rsp_t div_rsp,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [31:0] result_value
    output logic [0:0]        m_tuser    // [0] divide_by_zero
);
    import kee_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SUM
    } state_t;

    state_t      state_reg,     state_next;
    logic [31:0] total_reg,     total_next;
    logic [31:0] term_reg,      term_next;
    logic [31:0] number_reg,    number_next;
    op_t         op_reg,        op_next;
    logic        flag_reg,      flag_next;
    entry_t      cmd_reg,       cmd_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_value_reg, out_value_next;
    logic        out_flag_reg,  out_flag_next;
    logic [31:0] product;
    logic [31:0] times_ten;
    logic        div_needed;

    assign product    = term_reg * number_reg;
    assign times_ten  = {number_reg[28:0], 3'b000} + {number_reg[30:0], 1'b0}
                      + {28'd0, entry.digit};
    assign div_needed = (op_reg == OP_DIVIDE) && (number_reg != '0);

    always_comb begin
        state_next       = state_reg;
        total_next       = total_reg;
        term_next        = term_reg;
        number_next      = number_reg;
        op_next          = op_reg;
        flag_next        = flag_reg;
        cmd_next         = cmd_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_value_next   = out_value_reg;
        out_flag_next    = out_flag_reg;
        pop              = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = term_reg;
        div_req.divisor  = number_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!empty) begin
                    pop      = 1'b1;
                    cmd_next = entry;
                    if (entry.kind == KIND_DIGIT) begin
                        number_next = times_ten;
                    end else begin
                        // apply the pending operator to the number entered
                        unique case (op_reg)
                            OP_PLUS: begin
                                total_next = total_reg + term_reg;
                                term_next  = number_reg;
                            end
                            OP_MINUS: begin
                                total_next = total_reg + term_reg;
                                term_next  = -number_reg;
                            end
                            OP_TIMES: begin
                                term_next = product;
                            end
                            OP_DIVIDE: begin
                                if (number_reg == '0) begin
                                    flag_next = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                        if (div_needed) begin
                            div_req.start = 1'b1;
                            state_next    = ST_DIV;
                        end else if (entry.kind == KIND_EVALUATE) begin
                            state_next = ST_SUM;
                        end else begin
                            op_next     = entry.op;
                            number_next = '0;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    term_next = div_rsp.quotient;
                    if (cmd_reg.kind == KIND_EVALUATE) begin
                        state_next = ST_SUM;
                    end else begin
                        op_next     = cmd_reg.op;
                        number_next = '0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_SUM: begin
                // hand out the total once the output register is free
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_value_next = total_reg + term_reg;
                    out_flag_next  = flag_reg;
                    total_next     = '0;
                    term_next      = '0;
                    number_next    = '0;
                    op_next        = OP_PLUS;
                    flag_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            term_reg      <= '0;
            number_reg    <= '0;
            op_reg        <= OP_PLUS;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            term_reg      <= term_next;
            number_reg    <= number_next;
            op_reg        <= op_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
        cmd_reg       <= cmd_next;
        out_value_reg <= out_value_next;
        out_flag_reg  <= out_flag_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_value_reg;
    assign m_tuser[0] = out_flag_reg;

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider result outside divide state");

endmodule

// File: design/keypad_expression_evaluator.sv
// keypad expression evaluator
// s_ channel: one key code per transfer (ascii digit, operator or '=').
// m_ channel: one transfer per '=', carrying the wrapped 32-bit total in
// m_tdata and the divide-by-zero flag in m_tuser.
// a classifier takes keys into a four-entry queue; an executor drains it.
// digit and +, -, * keys are each handled as the executor pops them. a '/'
// applied with a nonzero divisor runs a bit-serial divider, one quotient
// bit per cycle plus sign handling. '=' reaches m_ through the queue,
// the sum state and the output register, after any division it completes.
// keys past the per-expression limit are dropped by the classifier.
// when the receiver stalls, the result holds in the output register and
// the executor waits at the next '='; keys keep entering until the queue
// is full, then s_tready falls.
// a synchronous reset (aresetn low) clears the queue, the key count and
// the expression state to an empty expression with a pending plus.
module keypad_expression_evaluator #(
    parameter int MAX_LEN = kee_pkg::MAX_LEN_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] key_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] result_value
    output logic [0:0]  m_tuser     // [0] divide_by_zero
);
    import kee_pkg::*;

    entry_t   push_entry;
    entry_t   pop_entry;
    logic     push;
    logic     pop;
    logic     full;
    logic     empty;
    div_req_t div_req;
    div_rsp_t div_rsp;

    kee_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (full),
        .push       (push),
        .push_entry (push_entry)
    );

    kee_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .full       (full),
        .empty      (empty)
    );

    kee_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    kee_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (empty),
        .entry    (pop_entry),
        .pop      (pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: tb/keypad_expression_evaluator_checker.sv
`timescale 1ns / 1ps

module keypad_expression_evaluator_checker #(
    parameter int MAX_LEN = kee_pkg::MAX_LEN_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] key_code
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,    // [31:0] result_value
    input  logic [0:0]  m_tuser,    // [0] divide_by_zero
    output int          fail_count,
    output int          totals_owed
);
    import kee_pkg::*;

    // one evaluated expression as the m_ channel should carry it
    typedef struct packed {
        logic [31:0] total;
        logic        zero_div;
    } eval_result_t;

    eval_result_t owed_totals[$];

    // shadow of the expression state
    logic [31:0] sum_done;
    logic [31:0] term_acc;
    logic [31:0] entry_num;
    op_t         op_held;
    int unsigned keys_taken;
    logic        zdiv_seen;

    initial begin
        fail_count  = 0;
        totals_owed = 0;
    end

    // signed quotient, truncated toward zero, wrapping for min / -1
    function automatic logic [31:0] quotient_toward_zero(input logic [31:0] num,
                                                         input logic [31:0] den);
        logic [31:0] mag_num;
        logic [31:0] mag_den;
        logic [31:0] mag_q;
        mag_num = num[31] ? -num : num;
        mag_den = den[31] ? -den : den;
        mag_q   = mag_num / mag_den;
        return (num[31] ^ den[31]) ? -mag_q : mag_q;
    endfunction

    function automatic op_t key_to_op(input logic [7:0] key);
        if (key == KEY_PLUS)   return OP_PLUS;
        if (key == KEY_MINUS)  return OP_MINUS;
        if (key == KEY_TIMES)  return OP_TIMES;
        if (key == KEY_DIVIDE) return OP_DIVIDE;
        return OP_OTHER;
    endfunction

    task automatic clear_expression();
        sum_done   = '0;
        term_acc   = '0;
        entry_num  = '0;
        op_held    = OP_PLUS;
        keys_taken = 0;
        zdiv_seen  = 1'b0;
    endtask

    // apply the held operator to the number entered so far
    task automatic fold_held_op();
        case (op_held)
            OP_PLUS: begin
                sum_done = sum_done + term_acc;
                term_acc = entry_num;
            end
            OP_MINUS: begin
                sum_done = sum_done + term_acc;
                term_acc = -entry_num;
            end
            OP_TIMES: term_acc = term_acc * entry_num;
            OP_DIVIDE: begin
                if (entry_num != '0) term_acc = quotient_toward_zero(term_acc, entry_num);
                else zdiv_seen = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic take_key(input logic [7:0] key);
        if (key == KEY_EQUALS) begin
            fold_held_op();
            sum_done = sum_done + term_acc;
            owed_totals.push_back(eval_result_t'{sum_done, zdiv_seen});
            clear_expression();
        end else if (keys_taken < MAX_LEN - 1) begin
            keys_taken++;
            if (key >= KEY_ZERO && key <= KEY_NINE) begin
                entry_num = entry_num * 32'd10 + 32'(key - KEY_ZERO);
            end else begin
                fold_held_op();
                op_held   = key_to_op(key);
                entry_num = '0;
            end
        end
    endtask

    // watch both channels at each edge
    always @(posedge aclk) begin
        eval_result_t want;
        if (!aresetn) begin
            clear_expression();
            owed_totals.delete();
        end else begin
            if (s_tvalid && s_tready) take_key(s_tdata);

            if (m_tvalid && m_tready) begin
                if (owed_totals.size() == 0) begin
                    fail_count <= fail_count + 1;
                    $display("%0t: unexpected result, value %0d flag %0b", $time,
                             $signed(m_tdata), m_tuser[0]);
                end else begin
                    want = owed_totals.pop_front();
                    if (m_tdata !== want.total || m_tuser[0] !== want.zero_div) begin
                        fail_count <= fail_count + 1;
                        if (m_tdata !== want.total)
                            $display("%0t: result_value expected %0d got %0d", $time,
                                     $signed(want.total), $signed(m_tdata));
                        if (m_tuser[0] !== want.zero_div)
                            $display("%0t: divide_by_zero expected %0b got %0b", $time,
                                     want.zero_div, m_tuser[0]);
                    end
                end
            end
        end
        totals_owed <= owed_totals.size();
    end

endmodule

// File: tb/keypad_expression_evaluator_tb.sv
`timescale 1ns / 1ps

module keypad_expression_evaluator_tb;
    import kee_pkg::*;

    localparam int KEY_TARGET   = 1550;
    localparam int HOLD_CYCLES  = 600;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 80;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // [7:0] key_code
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;      // [31:0] result_value
    logic [0:0]  m_tuser;      // [0] divide_by_zero

    int          fail_count;
    int          totals_owed;
    int unsigned cycle_count = 0;

    // sender pacing and pressure controls
    int          burst_left = 0;
    bit          no_gaps    = 1'b0;
    bit          long_hold  = 1'b0;
    int unsigned keys_counted = 0;
    int unsigned expr_keys    = 0;

    always #6 aclk = ~aclk;

    keypad_expression_evaluator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    keypad_expression_evaluator_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .totals_owed (totals_owed)
    );

    // one key transfer, with bursts and gaps on the sender side
    task automatic send_key(input logic [7:0] key);
        int gap;
        if (!no_gaps && burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        // keys past the length limit are dropped, so they are not counted
        if (key == KEY_EQUALS) begin
            expr_keys = 0;
            keys_counted++;
        end else if (expr_keys < MAX_LEN_DEFAULT - 1) begin
            expr_keys++;
            keys_counted++;
        end
    endtask

    task automatic send_text(input string keys);
        for (int i = 0; i < keys.len(); i++) send_key(keys[i]);
    endtask

    // sender goes quiet until every owed total has arrived
    task automatic wait_for_totals();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (totals_owed != 0) @(posedge aclk);
    endtask

    task automatic send_number();
        int len;
        int pick;
        pick = $urandom_range(0, 19);
        case (pick)
            0, 1:    len = 0;
            2, 3: begin
                send_key(KEY_ZERO);
                len = 0;
            end
            4, 5:    len = $urandom_range(9, 11);
            default: len = $urandom_range(1, 3);
        endcase
        repeat (len) send_key(KEY_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic send_operator();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick < 4)       send_key(KEY_PLUS);
        else if (pick < 8)  send_key(KEY_MINUS);
        else if (pick < 11) send_key(KEY_TIMES);
        else if (pick < 14) send_key(KEY_DIVIDE);
        else                send_key(8'($urandom_range(0, 255)));
    endtask

    // random expression, possibly with stray or unknown keys, closed by '='
    task automatic send_expression();
        int terms;
        terms = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
        if ($urandom_range(0, 7) == 0) send_operator();
        for (int t = 0; t < terms; t++) begin
            send_number();
            if (t < terms - 1) send_operator();
        end
        send_key(KEY_EQUALS);
    endtask

    // receiver: ready pattern of its own, plus one long hold on request
    initial begin
        int mode;
        int span;
        int i;
        m_tready <= 1'b0;
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                long_hold = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(10, 150);
                i = 0;
                while (i < span && !long_hold) begin
                    case (mode)
                        0: m_tready <= 1'b1;
                        1: m_tready <= 1'($urandom_range(0, 1));
                        2: m_tready <= (i % 4 == 0);
                        default: m_tready <= (i > span / 2);
                    endcase
                    @(posedge aclk);
                    i++;
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("keypad_expression_evaluator verification failed");
            $finish;
        end
    end

    // stimulus and verdict
    initial begin
        bit pressed;
        bit paused;
        pressed = 1'b0;
        paused  = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: min / -1 wrap, divide by zero, unknown keys, empty expression
        send_text("65536*32768/4294967295=");
        send_text("7-0/0");
        send_key(8'h00);
        send_key(8'hFF);
        send_key(8'h01);
        send_text("+9=");
        send_key(KEY_EQUALS);
        wait_for_totals();

        // random expressions with some noise
        while (keys_counted < KEY_TARGET) begin
            if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(1, 6)) send_key(8'($urandom_range(0, 255)));
            end else begin
                send_expression();
            end

            // long receiver hold while short expressions pile up
            if (!pressed && keys_counted > 400) begin
                pressed   = 1'b1;
                long_hold = 1'b1;
                no_gaps   = 1'b1;
                repeat (40) begin
                    send_key(KEY_ZERO + 8'($urandom_range(0, 9)));
                    send_key(KEY_EQUALS);
                end
                no_gaps = 1'b0;
            end

            if (!paused && keys_counted > 1000) begin
                paused = 1'b1;
                wait_for_totals();
            end
        end
        send_key(KEY_EQUALS);

        wait_for_totals();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && totals_owed == 0) begin
            $display("keypad_expression_evaluator verification clean");
        end else begin
            $display("keypad_expression_evaluator verification failed");
        end
        $finish;
    end

endmodule
